### hw/rtl/vgarf_pkg.sv
package vgarf_pkg;

   localparam int unsigned PORT_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FILE_DEPTH = 256;
   localparam int unsigned COMP_W     = 6;
   localparam int unsigned PAL_W      = 3 * COMP_W;
   localparam int unsigned ATTR_DEPTH = 32;

   typedef logic [PORT_W-1:0] port_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [COMP_W-1:0] comp_type;
   typedef logic [PAL_W-1:0]  pal_type;

   // access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // I/O ports
   localparam port_type PORT_CRT_IDX_MONO  = 16'h03b4;
   localparam port_type PORT_CRT_DAT_MONO  = 16'h03b5;
   localparam port_type PORT_STAT1_MONO    = 16'h03ba;
   localparam port_type PORT_ATTR_IDX      = 16'h03c0;
   localparam port_type PORT_ATTR_DAT      = 16'h03c1;
   localparam port_type PORT_MISC_WR       = 16'h03c2;
   localparam port_type PORT_SEQ_IDX       = 16'h03c4;
   localparam port_type PORT_SEQ_DAT       = 16'h03c5;
   localparam port_type PORT_DAC_RD_IDX    = 16'h03c7;
   localparam port_type PORT_DAC_WR_IDX    = 16'h03c8;
   localparam port_type PORT_DAC_DAT       = 16'h03c9;
   localparam port_type PORT_FEAT_RD       = 16'h03ca;
   localparam port_type PORT_MISC_RD       = 16'h03cc;
   localparam port_type PORT_GFX_IDX       = 16'h03ce;
   localparam port_type PORT_GFX_DAT       = 16'h03cf;
   localparam port_type PORT_CRT_IDX_COLOR = 16'h03d4;
   localparam port_type PORT_CRT_DAT_COLOR = 16'h03d5;
   localparam port_type PORT_STAT1_COLOR   = 16'h03da;

   // DAC sub-index
   localparam logic [1:0] DAC_PHASE_RED   = 2'd0;
   localparam logic [1:0] DAC_PHASE_GREEN = 2'd1;
   localparam logic [1:0] DAC_PHASE_BLUE  = 2'd2;

   // attribute register indexes with special write masks
   localparam logic [4:0] ATTR_PAL_LAST   = 5'h0f;
   localparam logic [4:0] ATTR_MODE       = 5'h10;
   localparam logic [4:0] ATTR_OVERSCAN   = 5'h11;
   localparam logic [4:0] ATTR_PLANE_EN   = 5'h12;
   localparam logic [4:0] ATTR_HPAN       = 5'h13;
   localparam logic [4:0] ATTR_COLOR_SEL  = 5'h14;

   localparam byte_type MASK_ATTR_PAL   = 8'h3f;
   localparam byte_type MASK_ATTR_MODE  = ~8'h10;
   localparam byte_type MASK_ATTR_PLANE = ~8'hc0;
   localparam byte_type MASK_ATTR_LOW   = ~8'hf0;
   localparam byte_type MASK_MISC_OUT   = ~8'h10;

endpackage

### hw/rtl/vgarf_ram.sv
module vgarf_ram
   import vgarf_pkg::*;
#(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_ff;
   logic             rd_vld_ff;
   logic             byp_ff;
   logic [WIDTH-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff       <= mem_ff[raddr];
      byp_data_ff <= wdata;
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[raddr];
         byp_ff    <= we && (waddr == raddr);
      end
   end

   // write-first: a write to the address being read shows up next cycle
   assign rdata = byp_ff ? byp_data_ff : (rd_vld_ff ? rd_ff : '0);

endmodule

### hw/rtl/vga_io_register_file.sv
// VGA I/O port register file.
// Input channel req_*: one port access per item; req_tuser is the access kind
// (0 read, 1 write), req_tdata carries the port address and the write byte.
// Result channel rsp_*: exactly one item per access, carrying the read byte
// (zero for writes and for unknown ports), in access order.
// Latency: the result is valid in the cycle after the access is accepted.
// Throughput: one access per cycle. The CRT, sequencer and graphics files and
// the palette sit in RAMs read ahead at the next index/pointer, so a read of
// the current entry does not wait on the RAM.
// When the receiver stalls, the result holds in the output register and a new
// access is taken in the same cycle the old result leaves; req_tready is low
// during reset and while a result waits and rsp_tready is low.
// Reset (synchronous, active high) clears all indexes, pointers, the attribute
// flip-flop and misc registers, and marks every file and palette entry as
// zero at once; an access may be sent in the first cycle after reset.
module vga_io_register_file
   import vgarf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [15:0] port, [23:16] wdata
   input  logic        req_tuser,  // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [7:0] rdata
);

   logic     acc;
   logic     is_wr;
   port_type port;
   byte_type wdata;
   byte_type rdata;

   byte_type crt_index_ff, crt_index_in;
   byte_type seq_index_ff, seq_index_in;
   byte_type gfx_index_ff, gfx_index_in;
   logic     attr_flip_ff, attr_flip_in;
   logic [5:0] attr_index_ff, attr_index_in;
   byte_type attr_file_ff [ATTR_DEPTH];
   byte_type dac_read_ptr_ff, dac_read_ptr_in;
   byte_type dac_write_ptr_ff, dac_write_ptr_in;
   logic [1:0] dac_phase_ff, dac_phase_in;
   comp_type dac_stage_ff [2];
   comp_type dac_stage_in [2];
   byte_type misc_output_ff, misc_output_in;
   byte_type misc_feature_ff, misc_feature_in;
   logic     rsp_tvalid_ff;
   byte_type rsp_tdata_ff;

   logic     crt_we, seq_we, gfx_we, pal_we, attr_we;
   byte_type crt_rd, seq_rd, gfx_rd;
   pal_type  pal_rd, pal_wdata;
   byte_type attr_wval;
   logic [4:0] attr_sel;
   comp_type pal_comp;

   assign port       = req_tdata[15:0];
   assign wdata      = req_tdata[23:16];
   assign is_wr      = (req_tuser == CMD_WRITE);
   assign req_tready = !reset && (!rsp_tvalid_ff || rsp_tready);
   assign acc        = req_tvalid && req_tready;
   assign attr_sel   = attr_index_ff[4:0];
   assign pal_wdata  = {dac_stage_ff[0], dac_stage_ff[1], wdata[COMP_W-1:0]};

   always_comb begin
      case (dac_phase_ff)
         DAC_PHASE_RED:   pal_comp = pal_rd[PAL_W-1:2*COMP_W];
         DAC_PHASE_GREEN: pal_comp = pal_rd[2*COMP_W-1:COMP_W];
         default:         pal_comp = pal_rd[COMP_W-1:0];
      endcase
   end

   always_comb begin
      crt_index_in     = crt_index_ff;
      seq_index_in     = seq_index_ff;
      gfx_index_in     = gfx_index_ff;
      attr_flip_in     = attr_flip_ff;
      attr_index_in    = attr_index_ff;
      dac_read_ptr_in  = dac_read_ptr_ff;
      dac_write_ptr_in = dac_write_ptr_ff;
      dac_phase_in     = dac_phase_ff;
      dac_stage_in     = dac_stage_ff;
      misc_output_in   = misc_output_ff;
      misc_feature_in  = misc_feature_ff;
      crt_we           = 1'b0;
      seq_we           = 1'b0;
      gfx_we           = 1'b0;
      pal_we           = 1'b0;
      attr_we          = 1'b0;
      attr_wval        = wdata;
      rdata            = '0;

      if (acc && is_wr) begin
         unique case (port) inside
            PORT_CRT_IDX_MONO, PORT_CRT_IDX_COLOR: crt_index_in = wdata;
            PORT_CRT_DAT_MONO, PORT_CRT_DAT_COLOR: crt_we = 1'b1;
            PORT_SEQ_IDX: seq_index_in = wdata;
            PORT_SEQ_DAT: seq_we = 1'b1;
            PORT_GFX_IDX: gfx_index_in = wdata;
            PORT_GFX_DAT: gfx_we = 1'b1;
            PORT_ATTR_IDX: begin
               if (!attr_flip_ff) begin
                  attr_index_in = wdata[5:0];
               end else begin
                  attr_we = 1'b1;
                  case (attr_sel) inside
                     [5'h00:ATTR_PAL_LAST]:  attr_wval = wdata & MASK_ATTR_PAL;
                     ATTR_MODE:              attr_wval = wdata & MASK_ATTR_MODE;
                     ATTR_OVERSCAN:          attr_wval = wdata;
                     ATTR_PLANE_EN:          attr_wval = wdata & MASK_ATTR_PLANE;
                     ATTR_HPAN, ATTR_COLOR_SEL: attr_wval = wdata & MASK_ATTR_LOW;
                     default:                attr_we = 1'b0;
                  endcase
               end
               attr_flip_in = !attr_flip_ff;
            end
            PORT_DAC_RD_IDX: begin
               dac_read_ptr_in = wdata;
               dac_phase_in    = DAC_PHASE_RED;
            end
            PORT_DAC_WR_IDX: begin
               dac_write_ptr_in = wdata;
               dac_phase_in     = DAC_PHASE_RED;
            end
            PORT_DAC_DAT: begin
               if (dac_phase_ff == DAC_PHASE_BLUE) begin
                  pal_we           = 1'b1;
                  dac_phase_in     = DAC_PHASE_RED;
                  dac_write_ptr_in = dac_write_ptr_ff + 8'd1;
               end else begin
                  dac_stage_in[dac_phase_ff[0]] = wdata[COMP_W-1:0];
                  dac_phase_in = dac_phase_ff + 2'd1;
               end
            end
            PORT_MISC_WR: misc_output_in = wdata & MASK_MISC_OUT;
            PORT_STAT1_MONO, PORT_STAT1_COLOR: misc_feature_in = wdata;
            default: ;
         endcase
      end else if (acc) begin
         unique case (port) inside
            PORT_CRT_IDX_MONO, PORT_CRT_IDX_COLOR: rdata = crt_index_ff;
            PORT_CRT_DAT_MONO, PORT_CRT_DAT_COLOR: rdata = crt_rd;
            PORT_SEQ_IDX: rdata = seq_index_ff;
            PORT_SEQ_DAT: rdata = seq_rd;
            PORT_GFX_IDX: rdata = gfx_index_ff;
            PORT_GFX_DAT: rdata = gfx_rd;
            PORT_ATTR_IDX: rdata = attr_flip_ff ? '0 : {2'b00, attr_index_ff};
            PORT_ATTR_DAT: rdata = attr_file_ff[attr_sel];
            PORT_DAC_RD_IDX: rdata = dac_read_ptr_ff;
            PORT_DAC_WR_IDX: rdata = dac_write_ptr_ff;
            PORT_DAC_DAT: begin
               rdata = {2'b00, pal_comp};
               if (dac_phase_ff == DAC_PHASE_BLUE) begin
                  dac_phase_in    = DAC_PHASE_RED;
                  dac_read_ptr_in = dac_read_ptr_ff + 8'd1;
               end else begin
                  dac_phase_in = dac_phase_ff + 2'd1;
               end
            end
            PORT_MISC_RD: rdata = misc_output_ff;
            PORT_FEAT_RD: rdata = misc_feature_ff;
            PORT_STAT1_MONO, PORT_STAT1_COLOR: attr_flip_in = 1'b0;
            default: ;
         endcase
      end
   end

   // files are read at the index they will hold after this cycle
   vgarf_ram #(.WIDTH(BYTE_W), .DEPTH(FILE_DEPTH)) u_crt_ram (
      .clock (clock),
      .reset (reset),
      .we    (crt_we),
      .waddr (crt_index_ff),
      .wdata (wdata),
      .raddr (crt_index_in),
      .rdata (crt_rd)
   );

   vgarf_ram #(.WIDTH(BYTE_W), .DEPTH(FILE_DEPTH)) u_seq_ram (
      .clock (clock),
      .reset (reset),
      .we    (seq_we),
      .waddr (seq_index_ff),
      .wdata (wdata),
      .raddr (seq_index_in),
      .rdata (seq_rd)
   );

   vgarf_ram #(.WIDTH(BYTE_W), .DEPTH(FILE_DEPTH)) u_gfx_ram (
      .clock (clock),
      .reset (reset),
      .we    (gfx_we),
      .waddr (gfx_index_ff),
      .wdata (wdata),
      .raddr (gfx_index_in),
      .rdata (gfx_rd)
   );

   vgarf_ram #(.WIDTH(PAL_W), .DEPTH(FILE_DEPTH)) u_pal_ram (
      .clock (clock),
      .reset (reset),
      .we    (pal_we),
      .waddr (dac_write_ptr_ff),
      .wdata (pal_wdata),
      .raddr (dac_read_ptr_in),
      .rdata (pal_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         crt_index_ff     <= '0;
         seq_index_ff     <= '0;
         gfx_index_ff     <= '0;
         attr_flip_ff     <= 1'b0;
         attr_index_ff    <= '0;
         attr_file_ff     <= '{default: '0};
         dac_read_ptr_ff  <= '0;
         dac_write_ptr_ff <= '0;
         dac_phase_ff     <= DAC_PHASE_RED;
         dac_stage_ff     <= '{default: '0};
         misc_output_ff   <= '0;
         misc_feature_ff  <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         crt_index_ff     <= crt_index_in;
         seq_index_ff     <= seq_index_in;
         gfx_index_ff     <= gfx_index_in;
         attr_flip_ff     <= attr_flip_in;
         attr_index_ff    <= attr_index_in;
         if (attr_we) begin
            attr_file_ff[attr_sel] <= attr_wval;
         end
         dac_read_ptr_ff  <= dac_read_ptr_in;
         dac_write_ptr_ff <= dac_write_ptr_in;
         dac_phase_ff     <= dac_phase_in;
         dac_stage_ff     <= dac_stage_in;
         misc_output_ff   <= misc_output_in;
         misc_feature_ff  <= misc_feature_in;
         if (acc) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_tdata_ff <= rdata;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
